// ===== src/grid_first_fit_rectangle_placer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle placer
// Shorthand for clocked concurrent checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_FIRST_FIT_RECTANGLE_PLACER_TOP_DEFINES_SVH
`define GRID_FIRST_FIT_RECTANGLE_PLACER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFFRP_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GFFRP_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gffrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle placer package
// Sizes, request and response types, grid port bundle and mask helper.
// ----------------------------------------------------------------------------
package gffrp_pkg;

    // Grid extent along x (columns) and y (rows).
    localparam int MAX_W  = 32;
    localparam int MAX_H  = 32;
    localparam int X_AW   = $clog2(MAX_W);
    localparam int Y_AW   = $clog2(MAX_H);
    localparam int X_CW   = X_AW + 1;
    localparam int Y_CW   = Y_AW + 1;
    localparam int ROOM_W = 11;
    localparam int CFG_W  = 6;
    localparam int CFG_IW = 1;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Request modes.
    localparam logic MODE_PLACE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Room counter saturation value.
    localparam logic [ROOM_W-1:0] ROOM_MAX = '1;

    typedef struct packed {
        logic       mode;
        logic [5:0] rect_width;
        logic [5:0] rect_height;
    } t_req;

    typedef struct packed {
        logic              placed;
        logic [4:0]        anchor_x;
        logic [4:0]        anchor_y;
        logic [ROOM_W-1:0] room_number;
        logic              grid_full;
    } t_rsp;

    // One grid column: one occupancy bit per row.
    typedef logic [MAX_H-1:0] t_col;

    // Command bundle from the sequencer to the grid store.
    typedef struct packed {
        logic            clr;
        logic            we;
        logic [X_AW-1:0] waddr;
        t_col            wdata;
        logic [X_AW-1:0] raddr;
    } t_grid_cmd;

    // Mask with the low n bits set, n from zero to MAX_H.
    function automatic t_col low_mask(input logic [Y_CW-1:0] n);
        logic [MAX_H:0] one_hot;
        one_hot = (MAX_H+1)'(1) << n;
        return t_col'(one_hot - (MAX_H+1)'(1));
    endfunction

endpackage

// ===== src/gffrp_grid.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid store
// One column word per x, one write and one registered read per cycle.
// Per-column valid bits make the whole grid read as empty after a clear.
// ----------------------------------------------------------------------------
module gffrp_grid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gffrp_pkg::t_grid_cmd i_cmd,
    output gffrp_pkg::t_col     o_rdata
);

    logic [gffrp_pkg::MAX_W-1:0] r_vld;
    gffrp_pkg::t_col             r_mem [gffrp_pkg::MAX_W];
    gffrp_pkg::t_col             r_rd_q;
    logic                        r_rd_v;

    // Column valid bits: a clear drops them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= r_vld[i_cmd.raddr];
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (i_cmd.we) begin
                r_vld[i_cmd.waddr] <= 1'b1;
            end
        end
    end

    // Column storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rd_q <= r_mem[i_cmd.raddr];
    end

    // A column never written since the last clear reads as empty.
    assign o_rdata = r_rd_v ? r_rd_q : '0;

endmodule

// ===== src/grid_first_fit_rectangle_placer_top.sv =====
// ----------------------------------------------------------------------------
// First-fit rectangle placer, top level
// Clear: wipe the grid, then run the full check. Place: per anchor column, read and OR the
// covered columns and scan the rows, then stamp the claimed rows and run the full check.
// One request at a time; the single grid read port and the bit-serial row scan set this.
// Reset (synchronous, active low) empties the grid, zeroes the room count, sizes to 32.
// ----------------------------------------------------------------------------
`include "grid_first_fit_rectangle_placer_top_defines.svh"

module grid_first_fit_rectangle_placer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [gffrp_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [gffrp_pkg::CFG_W-1:0]    i_cfg_data,
    // Request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gffrp_pkg::t_req                i_req,
    // Response channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gffrp_pkg::t_rsp                o_rsp
);

    localparam int X_AW = gffrp_pkg::X_AW;
    localparam int Y_AW = gffrp_pkg::Y_AW;
    localparam int X_CW = gffrp_pkg::X_CW;
    localparam int Y_CW = gffrp_pkg::Y_CW;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ACC_RD   = 9'b000000010,
        S_ACC_USE  = 9'b000000100,
        S_YSCAN    = 9'b000001000,
        S_STM_RD   = 9'b000010000,
        S_STM_WR   = 9'b000100000,
        S_FULL_RD  = 9'b001000000,
        S_FULL_CHK = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                          r_state, n_state;
    logic [gffrp_pkg::CFG_W-1:0]     r_gw, n_gw;
    logic [gffrp_pkg::CFG_W-1:0]     r_gh, n_gh;
    logic [gffrp_pkg::ROOM_W-1:0]    r_rooms, n_rooms;
    logic [X_CW-1:0]                 r_rw, n_rw;
    logic [Y_CW-1:0]                 r_rh, n_rh;
    logic [X_CW-1:0]                 r_ax, n_ax;
    logic [X_CW-1:0]                 r_k, n_k;
    logic [Y_CW-1:0]                 r_y, n_y;
    logic [Y_CW-1:0]                 r_run, n_run;
    logic [Y_CW-1:0]                 r_ay, n_ay;
    gffrp_pkg::t_col                 r_mask, n_mask;
    logic                            r_full, n_full;
    logic                            r_placed, n_placed;
    logic                            r_out_vld, n_out_vld;
    gffrp_pkg::t_rsp                 r_rsp, n_rsp;

    gffrp_pkg::t_grid_cmd            grid_cmd;
    gffrp_pkg::t_col                 grid_rdata;
    gffrp_pkg::t_col                 stamp;
    logic [X_CW-1:0]                 eff_w;
    logic [Y_CW-1:0]                 eff_h;
    logic [X_AW-1:0]                 col_addr;
    logic [Y_CW-1:0]                 run_inc;
    logic                            row_free;
    logic                            size_ok;

    gffrp_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (grid_cmd),
        .o_rdata (grid_rdata)
    );

    // In-use extents, saturated to the grid size.
    assign eff_w = (r_gw > gffrp_pkg::CFG_W'(gffrp_pkg::MAX_W)) ?
                   X_CW'(gffrp_pkg::MAX_W) : X_CW'(r_gw);
    assign eff_h = (r_gh > gffrp_pkg::CFG_W'(gffrp_pkg::MAX_H)) ?
                   Y_CW'(gffrp_pkg::MAX_H) : Y_CW'(r_gh);

    // Shared datapath terms.
    assign col_addr = X_AW'(r_ax + r_k);
    assign stamp    = gffrp_pkg::low_mask(r_rh) << r_ay[Y_AW-1:0];
    assign run_inc  = r_run + Y_CW'(1);
    assign row_free = !r_mask[r_y[Y_AW-1:0]];
    assign size_ok  = (i_req.rect_width != '0) && (i_req.rect_height != '0) &&
                      ({1'b0, i_req.rect_width} <= 7'(eff_w)) &&
                      ({1'b0, i_req.rect_height} <= 7'(eff_h)) &&
                      (r_rooms != gffrp_pkg::ROOM_MAX);

    // Sequencer and next-state logic.
    always_comb begin
        n_state   = r_state;
        n_gw      = r_gw;
        n_gh      = r_gh;
        n_rooms   = r_rooms;
        n_rw      = r_rw;
        n_rh      = r_rh;
        n_ax      = r_ax;
        n_k       = r_k;
        n_y       = r_y;
        n_run     = r_run;
        n_ay      = r_ay;
        n_mask    = r_mask;
        n_full    = r_full;
        n_placed  = r_placed;
        n_out_vld = r_out_vld & ~i_out_ready;
        n_rsp     = r_rsp;
        grid_cmd  = '0;

        if (i_cfg_we) begin
            if (i_cfg_idx == gffrp_pkg::CFG_GRID_WIDTH) begin
                n_gw = i_cfg_data;
            end else begin
                n_gh = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rw     = X_CW'(i_req.rect_width);
                    n_rh     = Y_CW'(i_req.rect_height);
                    n_ax     = '0;
                    n_ay     = '0;
                    n_k      = '0;
                    n_mask   = '0;
                    n_placed = 1'b0;
                    n_full   = 1'b1;
                    if (i_req.mode == gffrp_pkg::MODE_CLEAR) begin
                        grid_cmd.clr = 1'b1;
                        n_rooms      = '0;
                        n_state      = S_FULL_RD;
                    end else if (size_ok) begin
                        n_state = S_ACC_RD;
                    end else begin
                        n_state = S_FULL_RD;
                    end
                end
            end
            // Gather the OR of the rectangle's columns for this anchor x.
            S_ACC_RD: begin
                grid_cmd.raddr = col_addr;
                n_state        = S_ACC_USE;
            end
            S_ACC_USE: begin
                n_mask = r_mask | grid_rdata;
                if (X_CW'(r_k + X_CW'(1)) == r_rw) begin
                    n_y     = '0;
                    n_run   = '0;
                    n_state = S_YSCAN;
                end else begin
                    n_k     = r_k + X_CW'(1);
                    n_state = S_ACC_RD;
                end
            end
            // Walk the rows one a cycle, counting the run of free rows.
            S_YSCAN: begin
                if (row_free && run_inc == r_rh) begin
                    n_ay     = r_y + Y_CW'(1) - r_rh;
                    n_rooms  = r_rooms + gffrp_pkg::ROOM_W'(1);
                    n_placed = 1'b1;
                    n_k      = '0;
                    n_state  = S_STM_RD;
                end else begin
                    n_run = row_free ? run_inc : '0;
                    if (r_y + Y_CW'(1) == eff_h) begin
                        if ((X_CW+1)'(r_ax) + (X_CW+1)'(r_rw) + (X_CW+1)'(1) >
                            (X_CW+1)'(eff_w)) begin
                            n_k     = '0;
                            n_state = S_FULL_RD;
                        end else begin
                            n_ax    = r_ax + X_CW'(1);
                            n_k     = '0;
                            n_mask  = '0;
                            n_state = S_ACC_RD;
                        end
                    end else begin
                        n_y = r_y + Y_CW'(1);
                    end
                end
            end
            // Stamp the claimed rows into each covered column.
            S_STM_RD: begin
                grid_cmd.raddr = col_addr;
                n_state        = S_STM_WR;
            end
            S_STM_WR: begin
                grid_cmd.we    = 1'b1;
                grid_cmd.waddr = col_addr;
                grid_cmd.wdata = grid_rdata | stamp;
                if (X_CW'(r_k + X_CW'(1)) == r_rw) begin
                    n_k     = '0;
                    n_state = S_FULL_RD;
                end else begin
                    n_k     = r_k + X_CW'(1);
                    n_state = S_STM_RD;
                end
            end
            // Check every in-use column for a free row.
            S_FULL_RD: begin
                if (r_k == eff_w) begin
                    n_state = S_DONE;
                end else begin
                    grid_cmd.raddr = X_AW'(r_k);
                    n_state        = S_FULL_CHK;
                end
            end
            S_FULL_CHK: begin
                if ((grid_rdata | ~gffrp_pkg::low_mask(eff_h)) != '1) begin
                    n_full = 1'b0;
                end
                n_k     = r_k + X_CW'(1);
                n_state = S_FULL_RD;
            end
            // Hand the response to the output register once it is free.
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_rsp.placed      = r_placed;
                    n_rsp.anchor_x    = r_placed ? 5'(r_ax) : '0;
                    n_rsp.anchor_y    = r_placed ? 5'(r_ay) : '0;
                    n_rsp.room_number = r_placed ? r_rooms : '0;
                    n_rsp.grid_full   = r_full;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gw      <= gffrp_pkg::CFG_W'(gffrp_pkg::MAX_W);
            r_gh      <= gffrp_pkg::CFG_W'(gffrp_pkg::MAX_H);
            r_rooms   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gw      <= n_gw;
            r_gh      <= n_gh;
            r_rooms   <= n_rooms;
            r_out_vld <= n_out_vld;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_rw     <= n_rw;
        r_rh     <= n_rh;
        r_ax     <= n_ax;
        r_k      <= n_k;
        r_y      <= n_y;
        r_run    <= n_run;
        r_ay     <= n_ay;
        r_mask   <= n_mask;
        r_full   <= n_full;
        r_placed <= n_placed;
        r_rsp    <= n_rsp;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_rsp       = r_rsp;

    // Checks on the sequencer and the stamping path.
    `GFFRP_ASSERT_NEXT(a_busy_after_req, i_in_valid && o_in_ready, !o_in_ready,
        "placer took a request but stayed idle")
    `GFFRP_ASSERT_NOW(a_stamp_free, r_state == S_STM_WR, (grid_rdata & stamp) == '0,
        "placer stamped a cell that was already owned")
    `GFFRP_ASSERT_NOW(a_room_nonzero, o_out_valid && o_rsp.placed, o_rsp.room_number != '0,
        "placed response carries room number zero")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle placer regression
// Drives place and clear requests through the placer on several grid sizes.
// A scoreboard keeps its own occupancy grid and room count, works out the
// response to every accepted request, and checks each response in order.
// Both sides of the request path idle and stall at random.
// ----------------------------------------------------------------------------

// Occupancy grid shadow and in-order response checker.
class placement_scoreboard;
    logic [gffrp_pkg::ROOM_W-1:0] owner [gffrp_pkg::MAX_W][gffrp_pkg::MAX_H];
    int unsigned                  room_count;
    logic [gffrp_pkg::CFG_W-1:0]  width_reg;
    logic [gffrp_pkg::CFG_W-1:0]  height_reg;
    gffrp_pkg::t_rsp              expected_q[$];
    int unsigned                  mismatches;
    int unsigned                  responses;
    int unsigned                  placements;
    int unsigned                  clears;

    function new();
        wipe_grid();
        width_reg  = 6'd32;
        height_reg = 6'd32;
        mismatches = 0;
        responses  = 0;
        placements = 0;
        clears     = 0;
    endfunction

    function void wipe_grid();
        foreach (owner[x, y]) owner[x][y] = '0;
        room_count = 0;
    endfunction

    function void write_register(logic [gffrp_pkg::CFG_IW-1:0] idx,
                                 logic [gffrp_pkg::CFG_W-1:0] data);
        if (idx == gffrp_pkg::CFG_GRID_WIDTH) begin
            width_reg = data;
        end else begin
            height_reg = data;
        end
    endfunction

    // Register values beyond the grid saturate to the grid size.
    function int unsigned span(logic [gffrp_pkg::CFG_W-1:0] value, int unsigned limit);
        return (value > limit) ? limit : int'(value);
    endfunction

    function bit area_free(int unsigned ax, int unsigned ay, int unsigned rw,
                           int unsigned rh);
        for (int unsigned x = ax; x < ax + rw; x++) begin
            for (int unsigned y = ay; y < ay + rh; y++) begin
                if (owner[x][y] != '0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // First fit with x outer and y inner; stamps the next room on success.
    function gffrp_pkg::t_rsp place_or_clear(gffrp_pkg::t_req r);
        int unsigned     w;
        int unsigned     h;
        int unsigned     rw;
        int unsigned     rh;
        bit              all_owned;
        gffrp_pkg::t_rsp rsp;
        w   = span(width_reg, gffrp_pkg::MAX_W);
        h   = span(height_reg, gffrp_pkg::MAX_H);
        rw  = r.rect_width;
        rh  = r.rect_height;
        rsp = '0;
        if (r.mode == gffrp_pkg::MODE_CLEAR) begin
            wipe_grid();
            clears++;
        end else if (rw != 0 && rh != 0 && rw <= w && rh <= h &&
                     room_count < gffrp_pkg::ROOM_MAX) begin
            for (int unsigned ax = 0; ax + rw <= w && !rsp.placed; ax++) begin
                for (int unsigned ay = 0; ay + rh <= h && !rsp.placed; ay++) begin
                    if (area_free(ax, ay, rw, rh)) begin
                        room_count++;
                        for (int unsigned x = ax; x < ax + rw; x++) begin
                            for (int unsigned y = ay; y < ay + rh; y++) begin
                                owner[x][y] = gffrp_pkg::ROOM_W'(room_count);
                            end
                        end
                        rsp.placed      = 1'b1;
                        rsp.anchor_x    = 5'(ax);
                        rsp.anchor_y    = 5'(ay);
                        rsp.room_number = gffrp_pkg::ROOM_W'(room_count);
                        placements++;
                    end
                end
            end
        end
        // Full only counts cells inside the area in use; an empty area is full.
        all_owned = 1'b1;
        for (int unsigned x = 0; x < w; x++) begin
            for (int unsigned y = 0; y < h; y++) begin
                if (owner[x][y] == '0) all_owned = 1'b0;
            end
        end
        rsp.grid_full = all_owned;
        return rsp;
    endfunction

    function void note_request(gffrp_pkg::t_req r);
        gffrp_pkg::t_rsp want;
        want = place_or_clear(r);
        expected_q.insert(expected_q.size(), want);
    endfunction

    function void check_response(gffrp_pkg::t_rsp got);
        gffrp_pkg::t_rsp want;
        string           bad;
        responses++;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding: placed=%0b anchor=(%0d,%0d) room=%0d full=%0b",
                     $time, got.placed, got.anchor_x, got.anchor_y, got.room_number,
                     got.grid_full);
            return;
        end
        want = expected_q.pop_front();
        bad  = "";
        if (got.placed !== want.placed) bad = {bad, " placed"};
        if (got.anchor_x !== want.anchor_x) bad = {bad, " anchor_x"};
        if (got.anchor_y !== want.anchor_y) bad = {bad, " anchor_y"};
        if (got.room_number !== want.room_number) bad = {bad, " room_number"};
        if (got.grid_full !== want.grid_full) bad = {bad, " grid_full"};
        if (bad != "") begin
            mismatches++;
            $display("%0t: response %0d wrong in%s: expected placed=%0b anchor=(%0d,%0d) room=%0d full=%0b, actual placed=%0b anchor=(%0d,%0d) room=%0d full=%0b",
                     $time, responses, bad, want.placed, want.anchor_x, want.anchor_y,
                     want.room_number, want.grid_full, got.placed, got.anchor_x,
                     got.anchor_y, got.room_number, got.grid_full);
        end
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction
endclass

module tb;
    localparam int unsigned TIMEOUT_NS   = 12_000_000;
    localparam int unsigned SETTLE_CYCLES = 4000;
    localparam int unsigned IDLE_PCT     = 17;
    localparam int unsigned NUM_PHASES   = 7;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [gffrp_pkg::CFG_IW-1:0] i_cfg_idx   = '0;
    logic [gffrp_pkg::CFG_W-1:0]  i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    gffrp_pkg::t_req              i_req       = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    gffrp_pkg::t_rsp              o_rsp;

    placement_scoreboard sb = new();

    int unsigned in_idle_pct  = IDLE_PCT;
    int unsigned out_idle_pct = IDLE_PCT;
    int unsigned cur_w        = gffrp_pkg::MAX_W;
    int unsigned cur_h        = gffrp_pkg::MAX_H;
    int unsigned settings_used = 1;

    // Grid sizes for the random phases; the last one is picked at random.
    int unsigned phase_w [NUM_PHASES] = '{32, 4, 63, 1, 32, 0, 0};
    int unsigned phase_h [NUM_PHASES] = '{32, 6, 33, 32, 1, 9, 0};
    int unsigned phase_n [NUM_PHASES] = '{30, 20, 25, 15, 15, 10, 25};

    grid_first_fit_rectangle_placer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Response side stalls at random.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Every accepted response goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_response(o_rsp);
        end
    end

    // Present one request, with a random gap first, and hold it until accepted.
    task automatic send_request(input gffrp_pkg::t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req      <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    task automatic send_fields(input logic mode, input int unsigned w, input int unsigned h);
        gffrp_pkg::t_req r;
        r.mode        = mode;
        r.rect_width  = 6'(w);
        r.rect_height = 6'(h);
        send_request(r);
    endtask

    // Stop requesting and wait for every outstanding response.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [gffrp_pkg::CFG_IW-1:0] idx,
                                  input logic [gffrp_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic set_grid(input int unsigned w, input int unsigned h);
        write_register(gffrp_pkg::CFG_GRID_WIDTH, gffrp_pkg::CFG_W'(w));
        write_register(gffrp_pkg::CFG_GRID_HEIGHT, gffrp_pkg::CFG_W'(h));
        cur_w = (w > gffrp_pkg::MAX_W) ? gffrp_pkg::MAX_W : w;
        cur_h = (h > gffrp_pkg::MAX_H) ? gffrp_pkg::MAX_H : h;
        settings_used++;
    endtask

    // Either any extent up to the whole area or a small one, never zero.
    function automatic int unsigned pick_extent(int unsigned area, bit whole);
        int unsigned hi;
        hi = whole ? area : area / 3 + 1;
        return $urandom_range(hi == 0 ? 1 : hi, 1);
    endfunction

    // Mostly rectangles that can fit, some clears, some arbitrary sizes.
    function automatic gffrp_pkg::t_req random_request();
        gffrp_pkg::t_req r;
        int unsigned     roll;
        roll          = $urandom_range(99);
        r.mode        = gffrp_pkg::MODE_PLACE;
        r.rect_width  = 6'($urandom_range(63));
        r.rect_height = 6'($urandom_range(63));
        if (roll < 6) begin
            r.mode = gffrp_pkg::MODE_CLEAR;
        end else if (roll >= 14) begin
            r.rect_width  = 6'(pick_extent(cur_w, roll < 30));
            r.rect_height = 6'(pick_extent(cur_h, roll < 30));
        end
        return r;
    endfunction

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero sizes, oversize, a full-grid room, then first-fit order.
        send_fields(gffrp_pkg::MODE_PLACE, 0, 0);
        send_fields(gffrp_pkg::MODE_PLACE, 0, 5);
        send_fields(gffrp_pkg::MODE_PLACE, 7, 0);
        send_fields(gffrp_pkg::MODE_PLACE, 33, 1);
        send_fields(gffrp_pkg::MODE_PLACE, 63, 63);
        send_fields(gffrp_pkg::MODE_PLACE, 32, 32);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 1);
        send_fields(gffrp_pkg::MODE_CLEAR, 63, 63);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 1);
        send_fields(gffrp_pkg::MODE_PLACE, 2, 3);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 32);
        send_fields(gffrp_pkg::MODE_PLACE, 32, 1);

        // Shrinking the area keeps the rooms already stamped.
        drain();
        set_grid(3, 2);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 1);
        send_fields(gffrp_pkg::MODE_PLACE, 2, 2);

        // An area with no columns is full and nothing fits.
        drain();
        set_grid(0, 5);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 1);
        send_fields(gffrp_pkg::MODE_CLEAR, 0, 0);

        // Register values above the grid saturate.
        drain();
        set_grid(40, 63);
        send_fields(gffrp_pkg::MODE_PLACE, 32, 32);
        send_fields(gffrp_pkg::MODE_PLACE, 1, 1);
        send_fields(gffrp_pkg::MODE_CLEAR, 42, 21);

        // Random phases over several grid sizes; one phase runs without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p == NUM_PHASES - 1) begin
                set_grid($urandom_range(63), $urandom_range(63));
            end else begin
                set_grid(phase_w[p], phase_h[p]);
            end
            in_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
            out_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            repeat (phase_n[p]) send_request(random_request());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses: %0d rooms placed, %0d clears, %0d grid settings.",
                 sb.responses, sb.placements, sb.clears, settings_used);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d responses outstanding", $time, sb.outstanding());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/gffrp_pkg.sv
src/gffrp_grid.sv
src/grid_first_fit_rectangle_placer_top.sv
tb/sv/tb.sv
